>>> hdl/fmprt_pkg.sv
// shared types and codes for the first-match packet rule table
`timescale 1ns / 1ps

package fmprt_pkg;

  // item kinds; KIND_NONE also marks an add refused for a full table
  localparam logic [1:0] KIND_CHECK  = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // protocol value that matches any packet protocol
  localparam logic [7:0] PROTO_ANY = 8'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [7:0]  proto;
    logic        deny;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       drop;
  } rsp_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  proto;
    logic        deny;
  } rule_t;

  // operation travelling down the cell chain
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] address;
    logic [7:0]  proto;
    logic        deny;
    logic        hit;
    logic        grow;
    logic [1:0]  status;
    logic        drop;
  } token_t;

endpackage

>>> hdl/fmprt_cell.sv
// one rule slot of the chain: compares, updates and forwards the token
`timescale 1ns / 1ps

module fmprt_cell #(
  parameter int INDEX   = 0,
  parameter int TOTAL_W = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [TOTAL_W-1:0]   total,
  input  logic                 tok_valid_in,
  input  fmprt_pkg::token_t    tok_in,
  input  fmprt_pkg::rule_t     next_rule,
  output fmprt_pkg::rule_t     rule,
  output logic                 tok_valid,
  output fmprt_pkg::token_t    tok
);

  localparam logic [TOTAL_W-1:0] SLOT = TOTAL_W'(INDEX);

  fmprt_pkg::rule_t  rule_next;
  fmprt_pkg::token_t tok_next;
  logic used;
  logic addr_eq;
  logic exact;
  logic wild;

  // match against the stored rule
  always_comb begin
    used    = SLOT < total;
    addr_eq = used && (rule.address == tok_in.address);
    exact   = addr_eq && (rule.proto == tok_in.proto);
    wild    = addr_eq && ((rule.proto == fmprt_pkg::PROTO_ANY) ||
                          (rule.proto == tok_in.proto));
  end

  // per-operation update of the slot and the token
  always_comb begin
    rule_next = rule;
    tok_next  = tok_in;
    case (tok_in.op)
      fmprt_pkg::KIND_CHECK: begin
        if (!tok_in.hit && wild) begin
          tok_next.hit  = 1'b1;
          tok_next.drop = rule.deny;
        end
      end
      fmprt_pkg::KIND_ADD: begin
        if (!tok_in.hit) begin
          if (exact) begin
            rule_next.deny = tok_in.deny;
            tok_next.hit   = 1'b1;
          end else if (SLOT == total) begin
            rule_next.address = tok_in.address;
            rule_next.proto   = tok_in.proto;
            rule_next.deny    = tok_in.deny;
            tok_next.hit      = 1'b1;
            tok_next.grow     = 1'b1;
          end
        end
      end
      fmprt_pkg::KIND_DELETE: begin
        // from the first exact match on, each slot pulls its right neighbor
        if (tok_in.hit || exact) begin
          rule_next    = next_rule;
          tok_next.hit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // token valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= tok_valid_in;
    end
  end

  // token payload and rule storage
  always_ff @(posedge clk) begin
    if (advance) begin
      tok <= tok_next;
      if (tok_valid_in) begin
        rule <= rule_next;
      end
    end
  end

endmodule

>>> hdl/first_match_packet_rule_table.sv
// First-match packet rule table.
// Request channel (req_valid, req_stall, req) takes one item: check a
// packet, add or update a rule, or delete a rule. Response channel
// (rsp_valid, rsp_stall, rsp) returns one result per item, in order.
// Rules sit in a chain of TABLE_DEPTH cells, one rule per cell, in
// insertion order. An item travels down the chain one cell per cycle while
// the chain is not held; each cell matches it, updates its own rule and,
// on delete, pulls the rule of its right neighbor so the table closes
// the gap. The result is loaded from the last cell into the output register.
// One item is in the chain at a time; the next is accepted in the cycle
// after its predecessor leaves the chain. A result waiting in the output
// register does not block acceptance; if the receiver stalls and a second
// result reaches the chain end, the whole chain holds until the output
// register frees.
// Reset empties the table (rule count zero) and clears all valids; rule
// contents need no clearing.
`timescale 1ns / 1ps

module first_match_packet_rule_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  fmprt_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fmprt_pkg::rsp_t   rsp
);

  localparam int TOTAL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [TOTAL_W-1:0] FULL_COUNT = TOTAL_W'(TABLE_DEPTH);

  logic [TOTAL_W-1:0] total;
  logic               busy;
  logic               advance;
  logic               accept;
  logic               leave;
  logic               table_full;

  logic               tok_valid [TABLE_DEPTH+1];
  fmprt_pkg::token_t  tok       [TABLE_DEPTH+1];
  fmprt_pkg::rule_t   rule      [TABLE_DEPTH+1];
  fmprt_pkg::token_t  last;

  // chain holds only when a result must wait behind a stalled one
  // a new item enters only once the rule count of the previous one is settled
  assign last       = tok[TABLE_DEPTH];
  assign advance    = !(tok_valid[TABLE_DEPTH] && rsp_valid && rsp_stall);
  assign leave      = tok_valid[TABLE_DEPTH] && advance;
  assign req_stall  = busy;
  assign accept     = req_valid && !req_stall;
  assign table_full = total == FULL_COUNT;

  // build the token entering the first cell
  always_comb begin
    tok_valid[0]   = accept;
    tok[0].op      = req.kind;
    tok[0].address = req.address;
    tok[0].proto   = req.proto;
    tok[0].deny    = req.deny;
    tok[0].hit     = 1'b0;
    tok[0].grow    = 1'b0;
    tok[0].status  = fmprt_pkg::STATUS_OK;
    tok[0].drop    = 1'b0;
    if (req.kind == fmprt_pkg::KIND_ADD && table_full) begin
      tok[0].op     = fmprt_pkg::KIND_NONE;
      tok[0].status = fmprt_pkg::STATUS_FULL;
    end
  end

  // the last cell has no right neighbor
  assign rule[TABLE_DEPTH] = '0;

  // rule cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    fmprt_cell #(
      .INDEX   (i),
      .TOTAL_W (TOTAL_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (advance),
      .total        (total),
      .tok_valid_in (tok_valid[i]),
      .tok_in       (tok[i]),
      .next_rule    (rule[i+1]),
      .rule         (rule[i]),
      .tok_valid    (tok_valid[i+1]),
      .tok          (tok[i+1])
    );
  end

  // item in flight and rule count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      total <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (leave) begin
        busy <= 1'b0;
      end
      if (leave) begin
        if (last.op == fmprt_pkg::KIND_ADD && last.grow) begin
          total <= total + TOTAL_W'(1);
        end else if (last.op == fmprt_pkg::KIND_DELETE && last.hit) begin
          total <= total - TOTAL_W'(1);
        end
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (leave) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (leave) begin
      rsp.drop <= last.drop;
      if (last.op == fmprt_pkg::KIND_DELETE && !last.hit) begin
        rsp.status <= fmprt_pkg::STATUS_NOT_FOUND;
      end else begin
        rsp.status <= last.status;
      end
    end
  end

endmodule
